// ----- hw/rtl/mlpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared types and constants of the multi-level priority FIFO.
// ----------------------------------------------------------------------------
package mlpf_pkg;

	// Store depth and level count follow the fixed widths of the request
	// and result fields (6-bit entry index, 4-bit level, 7-bit occupancy).
	localparam int ENTRIES = 64;
	localparam int LEVELS  = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int BC_W    = 3;
	localparam int CFG_W   = 7;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LVL_W-1:0] lvl_t;
	typedef logic [OCC_W-1:0] occ_t;
	typedef logic [BC_W-1:0]  bc_t;

	typedef enum logic [1:0] {
		MODE_ENQ   = 2'd0,
		MODE_DEQ   = 2'd1,
		MODE_FLUSH = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BAD_PRIO = 2'd3
	} status_t;

	typedef enum logic {
		CFG_TOP_LEVEL = 1'b0,
		CFG_CAP_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_ENQ_WR,
		FSM_ENQ_LINK,
		FSM_DEQ_WR,
		FSM_DONE
	} fsm_t;

	// One write port and one read port of the link memory.
	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic we;
		idx_t wr_addr;
		idx_t wr_link;
		logic flush;
	} link_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mlpf_entry_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpf_entry_mem
// Entry store: payload word and byte count, one write and one registered read.
// ----------------------------------------------------------------------------
module mlpf_entry_mem
	import mlpf_pkg::*;
#(
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                    clk,
	input  wire                    we,
	input  idx_t                   wr_addr,
	input  wire [PAYLOAD_BITS-1:0] wr_payload,
	input  bc_t                    wr_count,
	input  wire                    rd_en,
	input  idx_t                   rd_addr,
	output logic [PAYLOAD_BITS-1:0] rd_payload,
	output bc_t                    rd_count
);

	logic [PAYLOAD_BITS-1:0] pay_mem [ENTRIES];
	bc_t                     cnt_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			pay_mem[wr_addr] <= wr_payload;
			cnt_mem[wr_addr] <= wr_count;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_payload <= pay_mem[rd_addr];
			rd_count   <= cnt_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/mlpf_link_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpf_link_mem
// Link store with per-entry valid bits; an entry not written since reset or
// flush reads as the next index, which forms the free chain in index order.
// ----------------------------------------------------------------------------
module mlpf_link_mem
	import mlpf_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  link_ctl_t ctl,
	output idx_t      rd_link
);

	idx_t               link_mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	idx_t               rd_data_s1;
	idx_t               rd_dflt_s1;
	logic               rd_vld_s1;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			link_mem[ctl.wr_addr] <= ctl.wr_link;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.flush) begin
			vld_q <= '0;
		end else if (ctl.we) begin
			vld_q[ctl.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_s1 <= link_mem[ctl.rd_addr];
			rd_vld_s1  <= vld_q[ctl.rd_addr];
			rd_dflt_s1 <= (ctl.rd_addr == IDX_W'(ENTRIES - 1)) ? '0 : ctl.rd_addr + 1'b1;
		end
	end

	assign rd_link = rd_vld_s1 ? rd_data_s1 : rd_dflt_s1;

endmodule
`default_nettype wire

// ----- hw/rtl/multi_level_priority_fifo_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_level_priority_fifo_core
// Priority queue with one FIFO per level over a shared linked entry store.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | in        | in_valid / in_stall | mode, priority_req, payload,
//          |           |                     | byte_count
//  out     | out       | out_valid/out_stall | status, out_payload,
//          |           |                     | out_byte_count, out_priority,
//          |           |                     | occupancy, ready_level_out
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// Accept to result in the output register: an enqueue onto a non-empty level
// passes ENQ_WR, ENQ_LINK, DONE; onto an empty level ENQ_WR, DONE; a dequeue
// DEQ_WR, DONE; a flush, reject or unused mode DONE only. The link memory has
// one write port, so the old tail's link is written in a state of its own.
// Reset leaves no clearing pass: link valid bits and the level non-empty bits
// clear at once, and the block takes a request as soon as reset is released.
// A stalled result holds in the output register; the next request is taken
// meanwhile and its result waits in the done state until the register frees.
// ----------------------------------------------------------------------------
module multi_level_priority_fifo_core
	import mlpf_pkg::*;
#(
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	// request channel
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire [1:0]               mode,
	input  wire [LVL_W-1:0]         priority_req,
	input  wire [PAYLOAD_BITS-1:0]  payload,
	input  wire [BC_W-1:0]          byte_count,
	// result channel
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [1:0]              status,
	output logic [PAYLOAD_BITS-1:0] out_payload,
	output logic [BC_W-1:0]         out_byte_count,
	output logic [LVL_W-1:0]        out_priority,
	output logic [OCC_W-1:0]        occupancy,
	output logic [LVL_W-1:0]        ready_level_out,
	// configuration
	input  wire                     cfg_we,
	input  wire                     cfg_index,
	input  wire [CFG_W-1:0]         cfg_data
);

	// Keep at most the low 32 payload bits; higher bits are masked off.
	localparam int KEEP_BITS = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
	localparam logic [PAYLOAD_BITS-1:0] PAY_MASK =
		{PAYLOAD_BITS{1'b1}} >> (PAYLOAD_BITS - KEEP_BITS);
	localparam occ_t CAP_MAX = OCC_W'(ENTRIES);

	// Highest set bit of vec at or below lim, else zero.
	function automatic lvl_t top_ready(input logic [LEVELS-1:0] vec, input lvl_t lim);
		lvl_t r;
		r = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (vec[i] && (LVL_W'(i) <= lim)) begin
				r = LVL_W'(i);
			end
		end
		return r;
	endfunction

	// configuration registers
	lvl_t top_level_q;
	occ_t cap_limit_q;

	// queue control state
	fsm_t               state_q, state_d;
	idx_t               free_head_q;
	occ_t               total_q;
	lvl_t               ready_q;
	logic [LEVELS-1:0]  nonempty_q;
	idx_t               head_q [LEVELS];
	idx_t               tail_q [LEVELS];

	// request held across its cycles
	idx_t                    idx_q;
	lvl_t                    lvl_q;
	idx_t                    old_tail_q;
	logic                    was_ne_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	bc_t                     cnt_q;

	// pending result
	status_t                 res_status_q;
	logic [PAYLOAD_BITS-1:0] res_payload_q;
	bc_t                     res_count_q;
	lvl_t                    res_prio_q;
	occ_t                    res_occ_q;
	lvl_t                    res_ready_q;

	// output register
	logic out_valid_q;

	// memory interfaces
	link_ctl_t               link_ctl;
	idx_t                    link_rd;
	logic                    entry_we;
	logic [PAYLOAD_BITS-1:0] entry_rd_payload;
	bc_t                     entry_rd_count;

	logic              acc;
	logic              out_free;
	occ_t              cap_eff;
	logic              enq_bad_prio;
	logic              enq_full;
	logic              deq_empty;
	logic              deq_drained;
	logic [LEVELS-1:0] deq_ne;
	lvl_t              deq_ready;
	lvl_t              enq_ready;

	assign in_stall = (state_q != FSM_IDLE);
	assign acc      = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// A capacity above the store acts as the store size.
	assign cap_eff      = (cap_limit_q > CAP_MAX) ? CAP_MAX : cap_limit_q;
	assign enq_bad_prio = (priority_req > top_level_q);
	assign enq_full     = (total_q >= cap_eff);
	assign deq_empty    = (total_q == '0) || !nonempty_q[ready_q];

	// Dequeue: drop the level when its head was also its tail, then walk down.
	assign deq_drained = (tail_q[lvl_q] == idx_q);
	always_comb begin
		deq_ne = nonempty_q;
		if (deq_drained) begin
			deq_ne[lvl_q] = 1'b0;
		end
	end
	assign deq_ready = top_ready(deq_ne, lvl_q);
	assign enq_ready = (lvl_q > ready_q) ? lvl_q : ready_q;

	// ------------------------------------------------------------------
	// Sequencer: next state and memory controls
	// ------------------------------------------------------------------
	always_comb begin
		state_d          = state_q;
		link_ctl         = '0;
		entry_we         = 1'b0;
		link_ctl.rd_addr = (mode == MODE_DEQ) ? head_q[ready_q] : free_head_q;
		case (state_q)
			FSM_IDLE: begin
				if (acc) begin
					link_ctl.rd_en = 1'b1;
					case (mode)
						MODE_ENQ: begin
							state_d = (enq_bad_prio || enq_full) ? FSM_DONE : FSM_ENQ_WR;
						end
						MODE_DEQ: begin
							state_d = deq_empty ? FSM_DONE : FSM_DEQ_WR;
						end
						MODE_FLUSH: begin
							link_ctl.flush = 1'b1;
							state_d        = FSM_DONE;
						end
						default: begin
							state_d = FSM_DONE;
						end
					endcase
				end
			end
			FSM_ENQ_WR: begin
				// New entry links to itself until another one follows it.
				entry_we         = 1'b1;
				link_ctl.we      = 1'b1;
				link_ctl.wr_addr = idx_q;
				link_ctl.wr_link = idx_q;
				state_d          = was_ne_q ? FSM_ENQ_LINK : FSM_DONE;
			end
			FSM_ENQ_LINK: begin
				link_ctl.we      = 1'b1;
				link_ctl.wr_addr = old_tail_q;
				link_ctl.wr_link = idx_q;
				state_d          = FSM_DONE;
			end
			FSM_DEQ_WR: begin
				// Push the freed entry onto the free chain.
				link_ctl.we      = 1'b1;
				link_ctl.wr_addr = idx_q;
				link_ctl.wr_link = free_head_q;
				state_d          = FSM_DONE;
			end
			FSM_DONE: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_level_q <= LVL_W'(LEVELS - 1);
			cap_limit_q <= CAP_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOP_LEVEL: top_level_q <= cfg_data[LVL_W-1:0];
				CFG_CAP_LIMIT: cap_limit_q <= cfg_data[OCC_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Queue control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			total_q     <= '0;
			ready_q     <= '0;
			nonempty_q  <= '0;
			was_ne_q    <= 1'b0;
		end else begin
			case (state_q)
				FSM_IDLE: begin
					if (acc) begin
						was_ne_q <= nonempty_q[priority_req];
						if (mode == MODE_FLUSH) begin
							free_head_q <= '0;
							total_q     <= '0;
							ready_q     <= '0;
							nonempty_q  <= '0;
						end
					end
				end
				FSM_ENQ_WR: begin
					free_head_q       <= link_rd;
					nonempty_q[lvl_q] <= 1'b1;
					total_q           <= total_q + 1'b1;
					ready_q           <= enq_ready;
				end
				FSM_DEQ_WR: begin
					free_head_q <= idx_q;
					nonempty_q  <= deq_ne;
					total_q     <= total_q - 1'b1;
					ready_q     <= deq_ready;
				end
				default: ;
			endcase
		end
	end

	// Level head and tail pointers; meaningful only while the level is non-empty.
	always_ff @(posedge clk) begin
		case (state_q)
			FSM_ENQ_WR: begin
				if (!was_ne_q) begin
					head_q[lvl_q] <= idx_q;
				end
				tail_q[lvl_q] <= idx_q;
			end
			FSM_DEQ_WR: begin
				if (!deq_drained) begin
					head_q[lvl_q] <= link_rd;
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Request hold and pending result
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				if (acc) begin
					idx_q         <= (mode == MODE_DEQ) ? head_q[ready_q] : free_head_q;
					lvl_q         <= (mode == MODE_DEQ) ? ready_q : priority_req;
					old_tail_q    <= tail_q[priority_req];
					pay_q         <= payload & PAY_MASK;
					cnt_q         <= byte_count;
					res_status_q  <= ST_OK;
					res_payload_q <= '0;
					res_count_q   <= '0;
					res_prio_q    <= '0;
					res_occ_q     <= total_q;
					res_ready_q   <= ready_q;
					case (mode)
						MODE_ENQ: begin
							if (enq_bad_prio) begin
								res_status_q <= ST_BAD_PRIO;
							end else if (enq_full) begin
								res_status_q <= ST_FULL;
							end
						end
						MODE_DEQ: begin
							if (deq_empty) begin
								res_status_q <= ST_EMPTY;
							end
						end
						MODE_FLUSH: begin
							res_occ_q   <= '0;
							res_ready_q <= '0;
						end
						default: ;
					endcase
				end
			end
			FSM_ENQ_WR: begin
				res_occ_q   <= total_q + 1'b1;
				res_ready_q <= enq_ready;
			end
			FSM_DEQ_WR: begin
				res_payload_q <= entry_rd_payload;
				res_count_q   <= entry_rd_count;
				res_prio_q    <= lvl_q;
				res_occ_q     <= total_q - 1'b1;
				res_ready_q   <= deq_ready;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: load from the done state, drop once taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == FSM_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == FSM_DONE) && out_free) begin
			status          <= res_status_q;
			out_payload     <= res_payload_q;
			out_byte_count  <= res_count_q;
			out_priority    <= res_prio_q;
			occupancy       <= res_occ_q;
			ready_level_out <= res_ready_q;
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Stores
	// ------------------------------------------------------------------
	mlpf_entry_mem #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_entry_mem (
		.clk        (clk),
		.we         (entry_we),
		.wr_addr    (idx_q),
		.wr_payload (pay_q),
		.wr_count   (cnt_q),
		.rd_en      (acc),
		.rd_addr    (head_q[ready_q]),
		.rd_payload (entry_rd_payload),
		.rd_count   (entry_rd_count)
	);

	mlpf_link_mem u_link_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (link_ctl),
		.rd_link (link_rd)
	);

endmodule
`default_nettype wire
